// File: hdl/pett_pkg.sv
`default_nettype none

package pett_pkg;

  // table size default and per-tick firing limit
  localparam int unsigned SlotsDef   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned FireCntW   = $clog2(MaxResults + 1);

  // time and field widths
  localparam int unsigned TimeW   = 48;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned KeyW    = 16;

  // result kinds
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_QUIET = 2'd3;

  // input item functions
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic               func;
    logic [KeyW-1:0]    event_key;
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] elapsed;
  } pett_in_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [KeyW-1:0] fired_key;
    logic            last;
  } pett_out_t;

  // one stored timer
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   due;
    logic               cancelled;
  } pett_entry_t;

endpackage

`default_nettype wire

// File: hdl/pett_mem.sv
`default_nettype none

module pett_mem #(
  parameter int unsigned SLOTS = pett_pkg::SlotsDef
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire  [$clog2(SLOTS)-1:0]   waddr_i,
  input  wire pett_pkg::pett_entry_t wdata_i,
  input  wire  [$clog2(SLOTS)-1:0]   raddr_i,
  output pett_pkg::pett_entry_t      rdata_o
);
  import pett_pkg::*;

  pett_entry_t mem_q [SLOTS];
  pett_entry_t rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/pett_alu.sv
`default_nettype none

module pett_alu (
  input  wire  [pett_pkg::TimeW-1:0]   add_a_i,
  input  wire  [pett_pkg::PeriodW-1:0] add_b_i,
  output logic [pett_pkg::TimeW-1:0]   sum_o,
  input  wire  [pett_pkg::TimeW-1:0]   cmp_a_i,
  input  wire  [pett_pkg::TimeW-1:0]   cmp_b_i,
  output logic                         ge_o
);
  import pett_pkg::*;

  logic [TimeW:0] raw_sum;

  // saturating time add
  always_comb begin
    raw_sum = {1'b0, add_a_i} + {{(TimeW + 1 - PeriodW){1'b0}}, add_b_i};
    sum_o   = raw_sum[TimeW] ? {TimeW{1'b1}} : raw_sum[TimeW-1:0];
  end

  // due check
  assign ge_o = (cmp_a_i >= cmp_b_i);

endmodule

`default_nettype wire

// File: hdl/periodic_event_timer_table.sv
`default_nettype none

// Periodic timer table. An item is taken when start is high and busy is low;
// busy then stays high until the item's last result has been presented. Each
// result appears on res_o for exactly one cycle with res_strobe_o high and
// must be captured then: the block cannot be stalled from the result side.
// The table lives in a single-port-read, single-port-write memory that is
// walked one entry per cycle through one shared 48-bit saturating adder and
// comparator. Fired results stream out during the walk, at most one per cycle.
// An add cancels every stored timer with the same key, then appends unless the
// table is full; a tick drops cancelled timers, compacts the table and fires
// every timer that is due, up to MaxResults per tick.
module periodic_event_timer_table #(
  parameter int unsigned SLOTS = pett_pkg::SlotsDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire pett_pkg::pett_in_t  item_i,
  output logic                     res_strobe_o,
  output pett_pkg::pett_out_t      res_o
);
  import pett_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_APPEND,
    ST_TICK_NOW,
    ST_TICK_SCAN,
    ST_FLUSH
  } state_e;

  state_e              state_q, state_d;
  pett_in_t            item_q, item_d;
  logic [CntW-1:0]     used_q, used_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     wr_q, wr_d;
  logic [FireCntW-1:0] nfire_q, nfire_d;
  logic                pend_vld_q, pend_vld_d;
  logic [KeyW-1:0]     pend_key_q, pend_key_d;
  logic                strobe_q, strobe_d;
  pett_out_t           res_q, res_d;

  // memory and shared unit hookup
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  pett_entry_t         mem_wdata;
  logic [IdxW-1:0]     mem_raddr;
  pett_entry_t         mem_rdata;
  logic [TimeW-1:0]    alu_a;
  logic [PeriodW-1:0]  alu_b;
  logic [TimeW-1:0]    alu_sum;
  logic                alu_ge;

  logic [CntW-1:0]     last_pos;
  logic                at_last;
  logic                fire;

  pett_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pett_alu u_alu (
    .add_a_i (alu_a),
    .add_b_i (alu_b),
    .sum_o   (alu_sum),
    .cmp_a_i (now_q),
    .cmp_b_i (mem_rdata.due),
    .ge_o    (alu_ge)
  );

  // scan position bookkeeping
  assign last_pos = used_q - CntW'(1);
  assign at_last  = ({{(CntW - IdxW){1'b0}}, pos_q} == last_pos);
  assign fire     = alu_ge && (nfire_q < FireCntW'(MaxResults));

  // shared adder operand select
  always_comb begin
    unique case (state_q)
      ST_TICK_SCAN: begin
        alu_a = mem_rdata.due;
        alu_b = mem_rdata.period;
      end
      ST_TICK_NOW: begin
        alu_a = now_q;
        alu_b = item_q.elapsed;
      end
      default: begin
        alu_a = now_q;
        alu_b = item_q.period;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    used_d     = used_q;
    now_d      = now_q;
    pos_d      = pos_q;
    wr_d       = wr_q;
    nfire_d    = nfire_q;
    pend_vld_d = pend_vld_q;
    pend_key_d = pend_key_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = pos_q;
    mem_wdata  = mem_rdata;
    mem_raddr  = pos_q + IdxW'(1);

    unique case (state_q)
      ST_IDLE: begin
        mem_raddr = '0;
        pos_d     = '0;
        if (start) begin
          item_d = item_i;
          if (item_i.func == FUNC_TICK) begin
            state_d = ST_TICK_NOW;
          end else if (used_q == '0) begin
            state_d = ST_ADD_APPEND;
          end else begin
            state_d = ST_ADD_SCAN;
          end
        end
      end

      // cancel stored timers with the same key
      ST_ADD_SCAN: begin
        if (mem_rdata.key == item_q.event_key) begin
          mem_we              = 1'b1;
          mem_waddr           = pos_q;
          mem_wdata           = mem_rdata;
          mem_wdata.cancelled = 1'b1;
        end
        pos_d = pos_q + IdxW'(1);
        if (at_last) begin
          state_d = ST_ADD_APPEND;
        end
      end

      // append or report full
      ST_ADD_APPEND: begin
        strobe_d        = 1'b1;
        res_d.fired_key = item_q.event_key;
        res_d.last      = 1'b1;
        if (used_q == CntW'(SLOTS)) begin
          res_d.kind = KIND_FULL;
        end else begin
          res_d.kind          = KIND_ADDED;
          mem_we              = 1'b1;
          mem_waddr           = used_q[IdxW-1:0];
          mem_wdata.key       = item_q.event_key;
          mem_wdata.period    = item_q.period;
          mem_wdata.due       = alu_sum;
          mem_wdata.cancelled = 1'b0;
          used_d              = used_q + CntW'(1);
        end
        state_d = ST_IDLE;
      end

      // advance time, start the walk
      ST_TICK_NOW: begin
        now_d      = alu_sum;
        mem_raddr  = '0;
        pos_d      = '0;
        wr_d       = '0;
        nfire_d    = '0;
        pend_vld_d = 1'b0;
        state_d    = (used_q == '0) ? ST_FLUSH : ST_TICK_SCAN;
      end

      // compact and fire, one entry per cycle
      ST_TICK_SCAN: begin
        if (!mem_rdata.cancelled) begin
          mem_we              = 1'b1;
          mem_waddr           = wr_q[IdxW-1:0];
          mem_wdata           = mem_rdata;
          mem_wdata.cancelled = 1'b0;
          if (fire) begin
            mem_wdata.due = alu_sum;
            nfire_d       = nfire_q + FireCntW'(1);
            pend_vld_d    = 1'b1;
            pend_key_d    = mem_rdata.key;
            if (pend_vld_q) begin
              strobe_d        = 1'b1;
              res_d.kind      = KIND_FIRED;
              res_d.fired_key = pend_key_q;
              res_d.last      = 1'b0;
            end
          end
          wr_d = wr_q + CntW'(1);
        end
        pos_d = pos_q + IdxW'(1);
        if (at_last) begin
          used_d  = wr_d;
          state_d = ST_FLUSH;
        end
      end

      // final result of a tick
      ST_FLUSH: begin
        strobe_d   = 1'b1;
        res_d.last = 1'b1;
        if (pend_vld_q) begin
          res_d.kind      = KIND_FIRED;
          res_d.fired_key = pend_key_q;
        end else begin
          res_d.kind      = KIND_QUIET;
          res_d.fired_key = '0;
        end
        pend_vld_d = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      now_q      <= '0;
      pos_q      <= '0;
      wr_q       <= '0;
      nfire_q    <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      now_q      <= now_d;
      pos_q      <= pos_d;
      wr_q       <= wr_d;
      nfire_q    <= nfire_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
      res_q      <= res_d;
    end
  end

  // item and pending key payload
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    pend_key_q <= pend_key_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

// File: tb/sv/timer_table_checker.sv
`timescale 1ns / 100ps

// watches the item and result channels of the timer table, keeps its own copy
// of the table, and compares every result with the oldest predicted one
module timer_table_checker
  import pett_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start_i,
  input  wire       busy_i,
  input  pett_in_t  item_i,
  input  wire       res_strobe_i,
  input  pett_out_t res_i,
  output int        mismatches_o,
  output int        pending_o
);

  // shadow copy of the timer table
  logic [KeyW-1:0]    timer_key    [SLOTS];
  logic [PeriodW-1:0] timer_period [SLOTS];
  logic [TimeW-1:0]   timer_due    [SLOTS];
  logic               timer_dead   [SLOTS];
  int unsigned        timer_count;
  logic [TimeW-1:0]   now_ticks;

  pett_out_t expected_q[$];
  int        errors;

  // 48-bit time plus 32-bit interval, clamped at the top of the range
  function automatic logic [TimeW-1:0] sat_sum(logic [TimeW-1:0] a, logic [PeriodW-1:0] b);
    logic [TimeW:0] s;
    s = a + b;
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  task automatic push_result(logic [1:0] kind, logic [KeyW-1:0] key, logic last);
    pett_out_t r;
    r.kind      = kind;
    r.fired_key = key;
    r.last      = last;
    expected_q.push_back(r);
  endtask

  // add: cancel every entry with this key, then append unless the table is full
  task automatic predict_add(pett_in_t it);
    for (int unsigned i = 0; i < timer_count; i++) begin
      if (timer_key[i] == it.event_key) timer_dead[i] = 1'b1;
    end
    if (timer_count >= SLOTS) begin
      push_result(KIND_FULL, it.event_key, 1'b1);
    end else begin
      timer_key[timer_count]    = it.event_key;
      timer_period[timer_count] = it.period;
      timer_due[timer_count]    = sat_sum(now_ticks, it.period);
      timer_dead[timer_count]   = 1'b0;
      timer_count++;
      push_result(KIND_ADDED, it.event_key, 1'b1);
    end
  endtask

  // tick: advance time, squeeze out cancelled entries, fire the due ones up to MaxResults
  task automatic predict_tick(pett_in_t it);
    int unsigned wr;
    int unsigned fired;
    pett_out_t   tail;
    wr    = 0;
    fired = 0;
    now_ticks = sat_sum(now_ticks, it.elapsed);
    for (int unsigned i = 0; i < timer_count; i++) begin
      if (timer_dead[i]) continue;
      if (wr != i) begin
        timer_key[wr]    = timer_key[i];
        timer_period[wr] = timer_period[i];
        timer_due[wr]    = timer_due[i];
        timer_dead[wr]   = 1'b0;
      end
      if (now_ticks >= timer_due[wr] && fired < MaxResults) begin
        push_result(KIND_FIRED, timer_key[wr], 1'b0);
        fired++;
        timer_due[wr] = sat_sum(timer_due[wr], timer_period[wr]);
      end
      wr++;
    end
    timer_count = wr;
    if (fired == 0) begin
      push_result(KIND_QUIET, '0, 1'b1);
    end else begin
      // mark the final fired event of this tick
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endtask

  task automatic check_result(pett_out_t got);
    pett_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: kind %0d key %h last %0d",
                 got.kind, got.fired_key, got.last);
    end else begin
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.fired_key !== want.fired_key ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d key %h last %0d, got kind %0d key %h last %0d",
                   want.kind, want.fired_key, want.last, got.kind, got.fired_key, got.last);
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_count = 0;
      now_ticks   = '0;
      errors      = 0;
      expected_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_strobe_i) check_result(res_i);
      if (start_i && !busy_i) begin
        if (item_i.func == FUNC_ADD) predict_add(item_i);
        else predict_tick(item_i);
      end
      mismatches_o <= errors;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// File: tb/sv/tb_periodic_event_timer_table.sv
`timescale 1ns / 100ps

module tb_periodic_event_timer_table;
  import pett_pkg::*;

  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned RandomItems  = 440;
  localparam int unsigned QuietTail    = 60;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PoolSize     = 24;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  pett_in_t  item   = '0;
  logic      busy;
  logic      res_strobe;
  pett_out_t res;
  int        mismatches;
  int        pending;
  int        idle_cycles = 0;

  // keys shared by every add so that replacement and cancellation happen often
  logic [KeyW-1:0] key_pool [PoolSize];

  periodic_event_timer_table #(
    .SLOTS(SlotsDef)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .res_strobe_o(res_strobe),
    .res_o       (res)
  );

  timer_table_checker #(
    .SLOTS(SlotsDef)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .res_strobe_i(res_strobe),
    .res_i       (res),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // unused fields carry random noise
  function automatic pett_in_t add_item(logic [KeyW-1:0] key, logic [PeriodW-1:0] per);
    pett_in_t it;
    it.func      = FUNC_ADD;
    it.event_key = key;
    it.period    = per;
    it.elapsed   = $urandom();
    return it;
  endfunction

  function automatic pett_in_t tick_item(logic [PeriodW-1:0] ela);
    pett_in_t it;
    it.func      = FUNC_TICK;
    it.event_key = KeyW'($urandom());
    it.period    = $urandom();
    it.elapsed   = ela;
    return it;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send(pett_in_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int unsigned        r;
    logic               idle_on;
    logic [KeyW-1:0]    key;
    logic [PeriodW-1:0] per;
    logic [PeriodW-1:0] ela;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) key_pool[i] = KeyW'($urandom());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: quiet tick on an empty table, zero and maximum periods
    send(tick_item('0));
    send(add_item(key_pool[0], '0));
    send(add_item(key_pool[1], '1));
    send(tick_item('0));
    send(tick_item('1));
    // replace key 0, then fill the table
    send(add_item(key_pool[0], 32'd5));
    for (int i = 1; i <= 13; i++) send(add_item(key_pool[i + 1], PeriodW'(i)));
    // full table still cancels the matching entry; next tick compacts
    send(add_item(key_pool[1], 32'd7));
    send(tick_item(32'd10));
    send(tick_item(32'd3));

    // random part
    idle_on = 1'b0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);

      // let the block drain completely once
      if (n == RandomItems / 2) begin
        start <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end

      if ($urandom_range(0, 99) < 48) begin
        key = key_pool[$urandom_range(0, PoolSize - 1)];
        r = $urandom_range(0, 99);
        if (r < 10)      per = '0;
        else if (r < 55) per = $urandom_range(1, 32);
        else if (r < 88) per = $urandom_range(33, 2000);
        else             per = $urandom();
        send(add_item(key, per));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8)       ela = '0;
        else if (r < 75) ela = $urandom_range(1, 24);
        else if (r < 96) ela = $urandom_range(25, 3000);
        else             ela = $urandom();
        send(tick_item(ela));
      end

      // sender gaps, none near the end
      if (idle_on && n < RandomItems - QuietTail && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end

    // drain and settle
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: periodic_event_timer_table.f
hdl/pett_pkg.sv
hdl/pett_mem.sv
hdl/pett_alu.sv
hdl/periodic_event_timer_table.sv
tb/sv/timer_table_checker.sv
tb/sv/tb_periodic_event_timer_table.sv
